// File: hdl/dvrt_pkg.sv
// Shared types, codes and helpers for the distance-vector route table unit.
// No dependencies; used by the top level and its checker.
package dvrt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_ADV  = 3'd1,
        OP_TICK = 3'd2,
        OP_KILL = 3'd3,
        OP_READ = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_IGN   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    localparam logic [7:0] CFG_INF = 8'd0;
    localparam logic [7:0] CFG_CL  = 8'd1;
    localparam logic [7:0] CFG_TTD = 8'd2;
    localparam logic [7:0] CFG_TTR = 8'd3;

    // one table slot as held in the RAM
    typedef struct packed {
        logic [15:0] own_dist;
        logic [7:0]  countdown;
        logic        reachable;
        logic [15:0] metric;
        logic [31:0] via;
        logic [5:0]  prefix;
        logic [31:0] addr;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic [15:0] distance;
        logic [31:0] via_addr;
        logic [5:0]  prefix_len;
        logic [31:0] net_addr;
        logic [5:0]  entry_index;
    } t_req;

    typedef struct packed {
        logic [7:0]  entry_countdown;
        logic        entry_reachable;
        logic [15:0] entry_dist;
        logic [31:0] entry_via;
        logic [5:0]  entry_prefix;
        logic [31:0] entry_addr;
        logic        entry_present;
        logic [1:0]  status;
    } t_rsp;

    localparam int REQ_W      = $bits(t_req);
    localparam int RSP_W      = $bits(t_rsp);
    localparam int IN_DATA_W  = ((REQ_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RSP_W + 7) / 8) * 8;

    // network part of an address; prefix above 32 acts as 32
    function automatic logic [31:0] net_of(input logic [31:0] addr, input logic [5:0] plen);
        logic [31:0] mask;
        mask = (plen >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> plen);
        return addr & mask;
    endfunction

endpackage

// File: hdl/distance_vector_route_table_unit.sv
// Distance-vector route table unit: top level with sequencer and slot RAM.
// Depends on dvrt_pkg and dvrt_ram.
//
// Each slot visited by a scan is read from the RAM, then evaluated and written
// back; a skipped slot goes straight on to the next. A free-slot search checks
// the slots in order. An advertisement runs the sender scan, the match scan and
// possibly a free search. A round tick scans the table once, plus a full kill
// scan for every neighbour it kills. One beat in flight at a time; the slot
// RAM's single read port sets the pace.
// Reset (synchronous, active low) clears the valid and direct flags and the
// handshake state and reloads the registers; the RAM needs no clearing pass.
module distance_vector_route_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata low to high: entry_index, net_addr, prefix_len, via_addr, distance
    input  logic [dvrt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: op
    input  logic [2:0]                      i_s_axis_tuser,
    // result channel
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata low to high: status, entry_present, entry_addr, entry_prefix,
    // entry_via, entry_dist, entry_reachable, entry_countdown
    output logic [dvrt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // register write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [7:0]                      i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);

    localparam int IW = dvrt_pkg::IDX_W;
    localparam logic [IW-1:0] LAST = IW'(dvrt_pkg::TABLE_ENTRIES - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EV   = 5'b00100,
        S_FREE = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    // what the current scan is doing
    typedef enum logic [2:0] {
        M_SENDER, M_MATCH, M_TICK, M_KILL, M_KSEL, M_READ, M_DIRECT, M_NEW
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_ret, n_ret;          // outer tick slot during a kill chain
    logic          r_tick_kill, n_tick_kill;
    logic [31:0]   r_kaddr, n_kaddr;      // address of the neighbour being killed
    logic [15:0]   r_sum, n_sum;
    logic          r_inb, n_inb;          // requested index within the table
    dvrt_pkg::t_req    r_in, n_in;
    dvrt_pkg::t_op     r_op, n_op;
    dvrt_pkg::t_status r_status, n_status;
    logic              r_present, n_present;
    dvrt_pkg::t_slot   r_entry, n_entry;

    logic [dvrt_pkg::TABLE_ENTRIES-1:0] r_valid, r_direct;
    logic set_valid, clr_valid, set_direct;

    logic r_m_valid, n_m_valid;
    logic [dvrt_pkg::OUT_DATA_W-1:0] r_m_data, n_m_data;

    logic [15:0] r_inf, r_cl;
    logic [7:0]  r_ttd, r_ttr;

    // RAM port signals
    logic            we;
    dvrt_pkg::t_slot wslot, rslot;
    logic [dvrt_pkg::SLOT_W-1:0] rdata;

    logic        in_acc, elig, adv, withdraw, kill_hit;
    logic [16:0] sum_w;
    logic [7:0]  dec_cd;
    dvrt_pkg::t_rsp rsp;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_cfg_ready     = 1'b1;
    assign rslot           = dvrt_pkg::t_slot'(rdata);
    assign withdraw        = r_in.distance >= r_inf;

    dvrt_ram #(
        .WIDTH(dvrt_pkg::SLOT_W),
        .DEPTH(dvrt_pkg::TABLE_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_idx),
        .i_wdata(wslot),
        .i_raddr(r_idx),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_ret       = r_ret;
        n_tick_kill = r_tick_kill;
        n_kaddr     = r_kaddr;
        n_sum       = r_sum;
        n_inb       = r_inb;
        n_in        = r_in;
        n_op        = r_op;
        n_status    = r_status;
        n_present   = r_present;
        n_entry     = r_entry;
        n_m_valid   = r_m_valid && !i_m_axis_tready;
        n_m_data    = r_m_data;
        we          = 1'b0;
        wslot       = rslot;
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        set_direct  = 1'b0;
        elig        = 1'b0;
        adv         = 1'b0;
        kill_hit    = 1'b0;
        sum_w       = 17'({1'b0, r_in.distance}) + 17'({1'b0, rslot.own_dist});
        dec_cd      = 8'd0;
        rsp         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_in      = dvrt_pkg::t_req'(i_s_axis_tdata[dvrt_pkg::REQ_W-1:0]);
                    n_op      = dvrt_pkg::t_op'(i_s_axis_tuser);
                    n_inb     = 32'(n_in.entry_index) < dvrt_pkg::TABLE_ENTRIES;
                    n_present = 1'b0;
                    n_entry   = '0;
                    n_status  = dvrt_pkg::ST_DONE;
                    n_idx     = '0;
                    n_state   = S_RD;
                    case (n_op)
                        dvrt_pkg::OP_LOAD: begin
                            n_mode  = M_DIRECT;
                            n_state = S_FREE;
                        end
                        dvrt_pkg::OP_ADV:  n_mode = M_SENDER;
                        dvrt_pkg::OP_TICK: n_mode = M_TICK;
                        dvrt_pkg::OP_KILL: begin
                            n_mode = M_KSEL;
                            n_idx  = IW'(n_in.entry_index);
                        end
                        dvrt_pkg::OP_READ: begin
                            n_mode = M_READ;
                            n_idx  = IW'(n_in.entry_index);
                        end
                        default: begin
                            n_status = dvrt_pkg::ST_IGN;
                            n_state  = S_FIN;
                        end
                    endcase
                end
            end

            S_RD: begin
                case (r_mode)
                    M_SENDER: elig = r_direct[r_idx];
                    M_KSEL:   elig = r_inb && (r_valid[r_idx] || r_direct[r_idx]);
                    M_READ:   elig = r_inb && r_valid[r_idx];
                    default:  elig = r_valid[r_idx];
                endcase
                if (elig) begin
                    n_state = S_EV;
                end else if (r_mode == M_KSEL || r_mode == M_READ) begin
                    n_status = dvrt_pkg::ST_EMPTY;
                    n_state  = S_FIN;
                end else begin
                    adv = 1'b1;
                end
            end

            S_EV: begin
                case (r_mode)
                    M_SENDER: begin
                        if (rslot.addr == r_in.via_addr) begin
                            we              = 1'b1;
                            wslot.countdown = r_ttd;
                            wslot.reachable = 1'b1;
                            wslot.via       = '0;
                            wslot.metric    = rslot.own_dist;
                            if (r_in.net_addr == rslot.addr) begin
                                n_state = S_FIN;
                            end else begin
                                n_sum   = (sum_w > 17'({1'b0, r_inf})) ? r_inf : sum_w[15:0];
                                n_mode  = M_MATCH;
                                n_idx   = '0;
                                n_state = S_RD;
                            end
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    M_MATCH: begin
                        if (dvrt_pkg::net_of(rslot.addr, rslot.prefix) ==
                            dvrt_pkg::net_of(r_in.net_addr, r_in.prefix_len)) begin
                            n_state = S_FIN;
                            if (withdraw) begin
                                if (rslot.reachable && rslot.via == r_in.via_addr) begin
                                    we              = 1'b1;
                                    wslot.reachable = 1'b0;
                                    wslot.countdown = r_ttd;
                                    wslot.metric    = r_inf;
                                end
                            end else if (rslot.metric > r_sum &&
                                         !(!rslot.reachable && rslot.countdown > r_ttr)) begin
                                we              = 1'b1;
                                wslot.via       = r_in.via_addr;
                                wslot.metric    = r_sum;
                                wslot.addr      = r_in.net_addr;
                                wslot.reachable = 1'b1;
                                wslot.countdown = r_ttd;
                            end
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    M_TICK: begin
                        we = 1'b1;
                        if (wslot.reachable && wslot.metric >= r_cl) begin
                            wslot.reachable = 1'b0;
                            wslot.countdown = r_ttd;
                            wslot.metric    = r_inf;
                        end
                        dec_cd = (wslot.countdown != 8'd0) ? wslot.countdown - 8'd1 : 8'd0;
                        if (wslot.via == 32'd0 && wslot.reachable) begin
                            if (dec_cd == 8'd0) begin
                                // silent neighbour: kill it and its routes
                                kill_hit        = 1'b1;
                                wslot.countdown = r_ttd;
                                wslot.metric    = r_inf;
                                wslot.reachable = 1'b0;
                            end else begin
                                wslot.countdown = dec_cd;
                            end
                        end else if (!wslot.reachable && wslot.via != 32'd0) begin
                            wslot.countdown = dec_cd;
                            clr_valid       = (dec_cd == 8'd0);
                        end else if (!wslot.reachable) begin
                            wslot.countdown = dec_cd;
                        end
                        if (kill_hit) begin
                            n_kaddr     = rslot.addr;
                            n_ret       = r_idx;
                            n_tick_kill = 1'b1;
                            n_mode      = M_KILL;
                            n_idx       = '0;
                            n_state     = S_RD;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    M_KILL: begin
                        if (rslot.via == r_kaddr) begin
                            we              = 1'b1;
                            wslot.reachable = 1'b0;
                            wslot.countdown = r_ttd;
                            wslot.metric    = r_inf;
                        end
                        adv = 1'b1;
                    end
                    M_KSEL: begin
                        we              = 1'b1;
                        wslot.countdown = r_ttd;
                        wslot.metric    = r_inf;
                        wslot.reachable = 1'b0;
                        if (rslot.reachable) begin
                            n_kaddr     = rslot.addr;
                            n_tick_kill = 1'b0;
                            n_mode      = M_KILL;
                            n_idx       = '0;
                            n_state     = S_RD;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    M_READ: begin
                        n_present = 1'b1;
                        n_entry   = rslot;
                        n_state   = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end

            S_FREE: begin
                if (!r_valid[r_idx] && !r_direct[r_idx]) begin
                    we              = 1'b1;
                    set_valid       = 1'b1;
                    wslot.addr      = r_in.net_addr;
                    wslot.prefix    = r_in.prefix_len;
                    wslot.reachable = 1'b1;
                    wslot.countdown = r_ttd;
                    if (r_mode == M_DIRECT) begin
                        set_direct     = 1'b1;
                        wslot.via      = '0;
                        wslot.metric   = r_in.distance;
                        wslot.own_dist = r_in.distance;
                    end else begin
                        wslot.via      = r_in.via_addr;
                        wslot.metric   = r_sum;
                        wslot.own_dist = '0;
                    end
                    n_state = S_FIN;
                end else if (r_idx == LAST) begin
                    n_status = dvrt_pkg::ST_FULL;
                    n_state  = S_FIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            S_FIN: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    rsp.status          = r_status;
                    rsp.entry_present   = r_present;
                    rsp.entry_addr      = r_entry.addr;
                    rsp.entry_prefix    = r_entry.prefix;
                    rsp.entry_via       = r_entry.via;
                    rsp.entry_dist      = r_entry.metric;
                    rsp.entry_reachable = r_entry.reachable;
                    rsp.entry_countdown = r_entry.countdown;
                    n_m_data            = dvrt_pkg::OUT_DATA_W'(rsp);
                    n_m_valid           = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // step to the next slot, or close the scan
        if (adv) begin
            if (r_idx != LAST) begin
                n_idx   = r_idx + IW'(1);
                n_state = S_RD;
            end else begin
                n_state = S_FIN;
                case (r_mode)
                    M_SENDER: n_status = dvrt_pkg::ST_IGN;
                    M_MATCH: begin
                        if (!withdraw) begin
                            n_mode  = M_NEW;
                            n_idx   = '0;
                            n_state = S_FREE;
                        end
                    end
                    M_KILL: begin
                        if (r_tick_kill) begin
                            n_mode = M_TICK;
                            if (r_ret != LAST) begin
                                n_idx   = r_ret + IW'(1);
                                n_state = S_RD;
                            end
                        end
                    end
                    default: n_status = r_status;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_valid   <= '0;
            r_direct  <= '0;
            r_inf     <= 16'd65535;
            r_cl      <= 16'd16;
            r_ttd     <= 8'd5;
            r_ttr     <= 8'd3;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            if (set_valid) r_valid[r_idx] <= 1'b1;
            if (clr_valid) r_valid[r_idx] <= 1'b0;
            if (set_direct) r_direct[r_idx] <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    dvrt_pkg::CFG_INF: r_inf <= i_cfg_data;
                    dvrt_pkg::CFG_CL:  r_cl  <= i_cfg_data;
                    dvrt_pkg::CFG_TTD: r_ttd <= i_cfg_data[7:0];
                    dvrt_pkg::CFG_TTR: r_ttr <= i_cfg_data[7:0];
                    default: r_inf <= r_inf;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_idx       <= n_idx;
        r_ret       <= n_ret;
        r_tick_kill <= n_tick_kill;
        r_kaddr     <= n_kaddr;
        r_sum       <= n_sum;
        r_inb       <= n_inb;
        r_in        <= n_in;
        r_op        <= n_op;
        r_status    <= n_status;
        r_present   <= n_present;
        r_entry     <= n_entry;
        r_m_data    <= n_m_data;
    end

endmodule

// File: hdl/dvrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/dvrt_checker.sv
// Port-level checks for the distance-vector route table unit, bound to the top.
// Depends on dvrt_pkg.
module dvrt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [dvrt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    // one request at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while busy");

    // stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

    // reset leaves the unit idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("not idle after reset");

endmodule

bind distance_vector_route_table_unit dvrt_checker u_dvrt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);

// File: dv/distance_vector_route_table_unit_test.sv
// Testbench for the distance-vector route table unit: directed table plus random traffic,
// every result checked against an in-bench route table predictor or an expected status in the table.
// Depends on dvrt_pkg and the distance_vector_route_table_unit RTL.
`timescale 1ns / 100ps

module distance_vector_route_table_unit_test;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [dvrt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [2:0]                      i_s_axis_tuser;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [dvrt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [7:0]                      i_cfg_index;
    logic [15:0]                     i_cfg_data;

    distance_vector_route_table_unit dut (.*);

    // 4 ns clock
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // ---------------- route table predictor ----------------
    logic [15:0] inf_dist, cnt_limit;
    logic [7:0]  die_rounds, restore_rounds;

    logic        rt_valid  [dvrt_pkg::TABLE_ENTRIES];
    logic        rt_direct [dvrt_pkg::TABLE_ENTRIES];
    logic        rt_reach  [dvrt_pkg::TABLE_ENTRIES];
    logic [31:0] rt_addr   [dvrt_pkg::TABLE_ENTRIES];
    logic [5:0]  rt_prefix [dvrt_pkg::TABLE_ENTRIES];
    logic [31:0] rt_via    [dvrt_pkg::TABLE_ENTRIES];
    logic [15:0] rt_dist   [dvrt_pkg::TABLE_ENTRIES];
    logic [7:0]  rt_cd     [dvrt_pkg::TABLE_ENTRIES];
    logic [15:0] rt_own    [dvrt_pkg::TABLE_ENTRIES];

    function automatic logic [31:0] masked_net(logic [31:0] a, logic [5:0] p);
        if (p == 0) return 32'd0;
        if (p >= 32) return a;
        return a & (32'hFFFF_FFFF << (32 - p));
    endfunction

    function automatic int first_free();
        for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++)
            if (!rt_valid[i] && !rt_direct[i]) return i;
        return -1;
    endfunction

    function automatic void route_lost(int i);
        rt_reach[i] = 1'b0;
        rt_cd[i]    = die_rounds;
        rt_dist[i]  = inf_dist;
    endfunction

    // neighbor down: if it was reachable, every route through it goes unreachable
    function automatic void neighbor_down(int n);
        logic was;
        was = rt_reach[n];
        rt_cd[n]   = die_rounds;
        rt_dist[n] = inf_dist;
        if (!was) return;
        rt_reach[n] = 1'b0;
        for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++)
            if (rt_valid[i] && rt_via[i] == rt_addr[n]) route_lost(i);
    endfunction

    function automatic void age_table();
        for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++) begin
            if (!rt_valid[i]) continue;
            if (rt_reach[i] && rt_dist[i] >= cnt_limit) route_lost(i);
            if (rt_via[i] == 0 && rt_reach[i]) begin
                if (rt_cd[i] != 0) rt_cd[i]--;
                if (rt_cd[i] == 0) neighbor_down(i);
            end else if (!rt_reach[i] && rt_via[i] != 0) begin
                if (rt_cd[i] != 0) rt_cd[i]--;
                if (rt_cd[i] == 0) rt_valid[i] = 1'b0;
            end else if (!rt_reach[i] && rt_cd[i] > 0) begin
                rt_cd[i]--;
            end
        end
    endfunction

    function automatic dvrt_pkg::t_status apply_advert(logic [31:0] a, logic [5:0] p,
                                                       logic [31:0] v, logic [15:0] d);
        int s, f;
        logic [16:0] total;
        logic [31:0] key;
        logic pull;
        s = -1;
        pull = (d >= inf_dist);
        for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++)
            if (rt_direct[i] && rt_addr[i] == v) begin s = i; break; end
        if (s < 0) return dvrt_pkg::ST_IGN;
        // sender refresh
        rt_cd[s] = die_rounds;
        rt_reach[s] = 1'b1;
        rt_via[s] = 32'd0;
        rt_dist[s] = rt_own[s];
        if (a == rt_addr[s]) return dvrt_pkg::ST_DONE;
        total = {1'b0, d} + {1'b0, rt_dist[s]};
        if (total > {1'b0, inf_dist}) total = {1'b0, inf_dist};
        key = masked_net(a, p);
        for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++) begin
            if (!rt_valid[i] || masked_net(rt_addr[i], rt_prefix[i]) != key) continue;
            if (pull) begin
                if (rt_reach[i] && rt_via[i] == v) route_lost(i);
            end else if ({1'b0, rt_dist[i]} > total) begin
                // hold-down: recently lost route refuses a better offer
                if (!rt_reach[i] && rt_cd[i] > restore_rounds) return dvrt_pkg::ST_DONE;
                rt_via[i] = v;
                rt_dist[i] = total[15:0];
                rt_addr[i] = a;
                rt_reach[i] = 1'b1;
                rt_cd[i] = die_rounds;
            end
            return dvrt_pkg::ST_DONE;
        end
        if (pull) return dvrt_pkg::ST_DONE;
        f = first_free();
        if (f < 0) return dvrt_pkg::ST_FULL;
        rt_valid[f] = 1'b1; rt_direct[f] = 1'b0;
        rt_addr[f] = a; rt_prefix[f] = p; rt_via[f] = v;
        rt_dist[f] = total[15:0]; rt_reach[f] = 1'b1;
        rt_cd[f] = die_rounds; rt_own[f] = 16'd0;
        return dvrt_pkg::ST_DONE;
    endfunction

    function automatic dvrt_pkg::t_rsp route_table_step(logic [2:0] op, dvrt_pkg::t_req r);
        dvrt_pkg::t_rsp o;
        int f;
        o = '0;
        o.status = dvrt_pkg::ST_IGN;
        case (op)
            dvrt_pkg::OP_LOAD: begin
                f = first_free();
                if (f < 0) o.status = dvrt_pkg::ST_FULL;
                else begin
                    rt_valid[f] = 1'b1; rt_direct[f] = 1'b1;
                    rt_addr[f] = r.net_addr; rt_prefix[f] = r.prefix_len;
                    rt_via[f] = 32'd0; rt_dist[f] = r.distance;
                    rt_reach[f] = 1'b1; rt_cd[f] = die_rounds;
                    rt_own[f] = r.distance;
                    o.status = dvrt_pkg::ST_DONE;
                end
            end
            dvrt_pkg::OP_ADV:
                o.status = apply_advert(r.net_addr, r.prefix_len, r.via_addr, r.distance);
            dvrt_pkg::OP_TICK: begin age_table(); o.status = dvrt_pkg::ST_DONE; end
            dvrt_pkg::OP_KILL: begin
                o.status = dvrt_pkg::ST_EMPTY;
                if (rt_valid[r.entry_index] || rt_direct[r.entry_index]) begin
                    neighbor_down(r.entry_index);
                    o.status = dvrt_pkg::ST_DONE;
                end
            end
            dvrt_pkg::OP_READ: begin
                o.status = dvrt_pkg::ST_EMPTY;
                if (rt_valid[r.entry_index]) begin
                    o.status = dvrt_pkg::ST_DONE;
                    o.entry_present   = 1'b1;
                    o.entry_addr      = rt_addr[r.entry_index];
                    o.entry_prefix    = rt_prefix[r.entry_index];
                    o.entry_via       = rt_via[r.entry_index];
                    o.entry_dist      = rt_dist[r.entry_index];
                    o.entry_reachable = rt_reach[r.entry_index];
                    o.entry_countdown = rt_cd[r.entry_index];
                end
            end
            default: o.status = dvrt_pkg::ST_IGN; // unknown op codes
        endcase
        return o;
    endfunction

    // ---------------- stimulus plumbing ----------------
    dvrt_pkg::t_rsp pending_rsp[$];
    int   mismatches, results_seen;
    int   op_count[8];
    int   tx_idle_pct, rx_idle_pct;

    // receiver back-pressure, changed at the falling edge
    always @(negedge i_clk)
        i_m_axis_tready = ($urandom_range(99) >= rx_idle_pct);

    task automatic note_miss(string fld, logic [31:0] e, logic [31:0] a);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH beat %0d %s: expected %h actual %h", results_seen, fld, e, a);
    endtask

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        dvrt_pkg::t_rsp got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[dvrt_pkg::RSP_W-1:0];
            results_seen++;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("MISMATCH unexpected result beat %h", got);
            end else begin
                want = pending_rsp.pop_front();
                if (got.status != want.status) note_miss("status", want.status, got.status);
                if (got.entry_present != want.entry_present)
                    note_miss("present", want.entry_present, got.entry_present);
                if (got.entry_addr != want.entry_addr)
                    note_miss("addr", want.entry_addr, got.entry_addr);
                if (got.entry_prefix != want.entry_prefix)
                    note_miss("prefix", want.entry_prefix, got.entry_prefix);
                if (got.entry_via != want.entry_via)
                    note_miss("via", want.entry_via, got.entry_via);
                if (got.entry_dist != want.entry_dist)
                    note_miss("dist", want.entry_dist, got.entry_dist);
                if (got.entry_reachable != want.entry_reachable)
                    note_miss("reachable", want.entry_reachable, got.entry_reachable);
                if (got.entry_countdown != want.entry_countdown)
                    note_miss("countdown", want.entry_countdown, got.entry_countdown);
            end
        end
    end

    // one request beat; called at a falling edge, returns at a falling edge
    task automatic send_beat(logic [2:0] op, dvrt_pkg::t_req r, bit typed,
                             dvrt_pkg::t_status typed_st);
        dvrt_pkg::t_rsp pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = '0;
        i_s_axis_tdata[dvrt_pkg::REQ_W-1:0] = r;
        i_s_axis_tuser  = op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = route_table_step(op, r);
        if (typed) begin
            pred = '0;
            pred.status = typed_st;
        end
        pending_rsp.push_back(pred);
        op_count[op]++;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // register write; only issued with the block idle
    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            dvrt_pkg::CFG_INF: inf_dist       = val;
            dvrt_pkg::CFG_CL:  cnt_limit      = val;
            dvrt_pkg::CFG_TTD: die_rounds     = val[7:0];
            dvrt_pkg::CFG_TTR: restore_rounds = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(logic [15:0] inf, logic [15:0] cl, logic [7:0] ttd, logic [7:0] ttr);
        drain();
        write_reg(dvrt_pkg::CFG_INF, inf);
        write_reg(dvrt_pkg::CFG_CL, cl);
        write_reg(dvrt_pkg::CFG_TTD, {8'd0, ttd});
        write_reg(dvrt_pkg::CFG_TTR, {8'd0, ttr});
    endtask

    // directed stimulus table
    typedef struct {
        logic [2:0]  op;
        logic [5:0]  idx;
        logic [31:0] net;
        logic [5:0]  plen;
        logic [31:0] via;
        logic [15:0] metric;
        bit          typed;
        dvrt_pkg::t_status st;
    } t_row;

    localparam logic [31:0] NB_A = 32'h0A00_0001;
    localparam logic [31:0] NB_B = 32'hFFFF_FFFF;

    t_row directed[] = '{
        // empty table
        '{dvrt_pkg::OP_READ, 6'd0, 32'd0, 6'd0, 32'd0, 16'd0, 1, dvrt_pkg::ST_EMPTY},
        // unknown ops
        '{3'd5, 6'd0, 32'd0, 6'd0, 32'd0, 16'd0, 1, dvrt_pkg::ST_IGN},
        '{3'd7, 6'h3F, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF, 1, dvrt_pkg::ST_IGN},
        // stranger
        '{dvrt_pkg::OP_ADV, 6'd0, 32'h0102_0300, 6'd24, 32'h0505_0505, 16'd1, 1,
          dvrt_pkg::ST_IGN},
        '{dvrt_pkg::OP_KILL, 6'h3F, 32'd0, 6'd0, 32'd0, 16'd0, 1, dvrt_pkg::ST_EMPTY},
        '{dvrt_pkg::OP_LOAD, 6'd0, NB_A, 6'd24, 32'd0, 16'd1, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_LOAD, 6'd0, NB_B, 6'd32, 32'd0, 16'd0, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_ADV, 6'd0, 32'hC0A8_0000, 6'd16, NB_A, 16'd2, 0, dvrt_pkg::ST_DONE},
        // own address
        '{dvrt_pkg::OP_ADV, 6'd0, NB_A, 6'd24, NB_A, 16'd0, 0, dvrt_pkg::ST_DONE},
        // better
        '{dvrt_pkg::OP_ADV, 6'd0, 32'hC0A8_1234, 6'd16, NB_B, 16'd1, 0, dvrt_pkg::ST_DONE},
        // withdraw
        '{dvrt_pkg::OP_ADV, 6'd0, 32'hC0A8_0000, 6'd16, NB_B, 16'hFFFF, 0,
          dvrt_pkg::ST_DONE},
        // saturates
        '{dvrt_pkg::OP_ADV, 6'd0, 32'h0000_0000, 6'd0, NB_A, 16'hFFFE, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_ADV, 6'd0, 32'hABCD_EF01, 6'h3F, NB_B, 16'd3, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_READ, 6'd2, 32'd0, 6'd0, 32'd0, 16'd0, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_TICK, 6'd0, 32'd0, 6'd0, 32'd0, 16'd0, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_TICK, 6'd0, 32'd0, 6'd0, 32'd0, 16'd0, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_READ, 6'd0, 32'd0, 6'd0, 32'd0, 16'd0, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_KILL, 6'd0, 32'd0, 6'd0, 32'd0, 16'd0, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_READ, 6'd1, 32'd0, 6'd0, 32'd0, 16'd0, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_READ, 6'd2, 32'd0, 6'd0, 32'd0, 16'd0, 0, dvrt_pkg::ST_DONE},
        '{dvrt_pkg::OP_READ, 6'h3F, 32'd0, 6'd0, 32'd0, 16'd0, 1, dvrt_pkg::ST_EMPTY}
    };

    // ---------------- random traffic ----------------
    logic [31:0] nbr_pool[4];
    logic [31:0] net_pool[8];
    logic [5:0]  plen_pool[8];

    task automatic random_burst(int count);
        dvrt_pkg::t_req r;
        logic [2:0] op;
        int k, pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 5)       op = dvrt_pkg::OP_LOAD;
            else if (pick < 55) op = dvrt_pkg::OP_ADV;
            else if (pick < 68) op = dvrt_pkg::OP_TICK;
            else if (pick < 76) op = dvrt_pkg::OP_KILL;
            else if (pick < 97) op = dvrt_pkg::OP_READ;
            else                op = 3'($urandom_range(7, 5)); // noise
            k = $urandom_range(7);
            r.entry_index = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(15));
            r.net_addr    = ($urandom_range(9) == 0) ? $urandom : net_pool[k] | $urandom_range(255);
            r.prefix_len  = ($urandom_range(9) == 0) ? 6'($urandom) : plen_pool[k];
            r.via_addr    = ($urandom_range(9) == 0) ? $urandom : nbr_pool[$urandom_range(3)];
            case ($urandom_range(9))
                0:       r.distance = 16'($urandom);
                1:       r.distance = inf_dist;
                default: r.distance = 16'($urandom_range(12));
            endcase
            if (op == dvrt_pkg::OP_LOAD && $urandom_range(4) != 0)
                r.net_addr = nbr_pool[$urandom_range(3)];
            send_beat(op, r, 0, dvrt_pkg::ST_DONE);
        end
    endtask

    initial begin
        dvrt_pkg::t_req r;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        tx_idle_pct = 6;
        rx_idle_pct = 81;
        mismatches = 0;
        results_seen = 0;
        inf_dist = 16'd65535; cnt_limit = 16'd16; die_rounds = 8'd5; restore_rounds = 8'd3;
        for (int i = 0; i < dvrt_pkg::TABLE_ENTRIES; i++) begin
            rt_valid[i] = 0; rt_direct[i] = 0; rt_reach[i] = 0;
            rt_addr[i] = '0; rt_prefix[i] = '0; rt_via[i] = '0;
            rt_dist[i] = '0; rt_cd[i] = '0; rt_own[i] = '0;
        end
        for (int i = 0; i < 8; i++) op_count[i] = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[j]) begin
            r.entry_index = directed[j].idx;
            r.net_addr    = directed[j].net;
            r.prefix_len  = directed[j].plen;
            r.via_addr    = directed[j].via;
            r.distance    = directed[j].metric;
            send_beat(directed[j].op, r, directed[j].typed, directed[j].st);
        end

        // six phases: two register settings per idling pattern
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin tx_idle_pct = 81; rx_idle_pct = 6; end
            if (ph == 4) begin tx_idle_pct = 0;  rx_idle_pct = 0; end
            case (ph)
                0: set_regs(16'd1, 16'd1, 8'd1, 8'd0);             // low extremes
                1: set_regs(16'd65535, 16'd65535, 8'd255, 8'd255); // high extremes
                2: set_regs(16'd65535, 16'd16, 8'd5, 8'd3);        // defaults
                default: set_regs(16'($urandom_range(65535, 8)), 16'($urandom_range(40, 1)),
                                  8'($urandom_range(8, 1)), 8'($urandom_range(6)));
            endcase
            foreach (nbr_pool[k]) nbr_pool[k] = $urandom | 32'h1;
            foreach (net_pool[k]) begin
                net_pool[k]  = $urandom & 32'hFFFF_FF00;
                plen_pool[k] = 6'($urandom_range(32, 8));
            end
            random_burst(75);
            if (ph == 3) drain(); // sender holds off until the table goes quiet
            random_burst(75);
        end

        drain();
        $display("Covered %0d loads, %0d adverts, %0d ticks, %0d kills, %0d reads, %0d noise",
                 op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
                 op_count[5] + op_count[6] + op_count[7]);
        $display("%0d results checked over six register settings and three idling patterns",
                 results_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial begin
        #40ms;
        $display("Timeout waiting for the route table");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
